[hdl/mde_pkg.sv]
// ----------------------------------------------------------------------------
// mde_pkg
// Shared sizes, codes and types of the multi-deque engine.
// ----------------------------------------------------------------------------
package mde_pkg;

	localparam int NUM_QUEUES  = 16;
	localparam int QUEUE_DEPTH = 256;
	localparam int ITEM_WIDTH  = 64;

	localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = (NUM_QUEUES * QUEUE_DEPTH > 1) ?
		$clog2(NUM_QUEUES * QUEUE_DEPTH) : 1;
	localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_POP_BACK   = 3'd3;
	localparam logic [2:0] ACT_PEEK_FRONT = 3'd4;
	localparam logic [2:0] ACT_PEEK_BACK  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [SLOT_W-1:0] front;
		logic [SLOT_W-1:0] back;
		logic [CNT_W-1:0]  count;
	} ctrl_t;

endpackage

[hdl/multi_deque_engine_top.sv]
// ----------------------------------------------------------------------------
// multi_deque_engine_top
// Bank of double-ended queues held in a control memory and an item memory.
//
//  channel   handshake                 payload
//  request   start, busy (in)          action, queue_id, item_data
//  result    done strobe (out)         status, item_out, queue_size
//
// A request is taken at an edge with start high and busy low; the control
// word is read at that edge. Push, unused codes and pop or peek on an empty
// queue pass through S_CTRL only (control read, then modify and write back);
// a pop or peek that finds an item goes on to S_DATA, which waits on the
// registered item memory read. done pulses in the cycle after the last state.
// busy covers the write back, so no access to a control word can overlap
// another. Reset clears the control valid bits at once; items need no
// clearing. Results cannot be stalled.
// ----------------------------------------------------------------------------
module multi_deque_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [3:0]  queue_id,
	input  logic [63:0] item_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] item_out,
	output logic [8:0]  queue_size
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CTRL = 2'd1;
	localparam logic [1:0] S_DATA = 2'd2;

	localparam int QSEL_W = mde_pkg::QSEL_W;
	localparam int SLOT_W = mde_pkg::SLOT_W;
	localparam int CNT_W  = mde_pkg::CNT_W;
	localparam int ADDR_W = mde_pkg::ADDR_W;
	localparam int IW     = mde_pkg::ITEM_WIDTH;

	logic [1:0]         state_q;
	logic               accept;

	logic [2:0]         act_s1;
	logic [QSEL_W-1:0]  qidx_s1;
	logic               in_range_s1;
	logic [IW-1:0]      data_s1;

	logic [1:0]         status_s2;
	logic [8:0]         size_s2;

	logic               done_q;
	logic [1:0]         status_q;
	logic [63:0]        item_out_q;
	logic [8:0]         queue_size_q;

	mde_pkg::ctrl_t     ctrl_rd;
	mde_pkg::ctrl_t     ctrl_nx;
	logic               ctrl_we;
	logic               item_we;
	logic               item_re;
	logic [SLOT_W-1:0]  slot;
	logic [ADDR_W-1:0]  item_addr;
	logic [1:0]         res_status;
	logic [CNT_W-1:0]   res_count;
	logic [IW-1:0]      item_rd;

	logic               is_push;
	logic               is_pop;
	logic               is_peek;
	logic               at_front;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	mde_ctrl_store u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (QSEL_W'(queue_id)),
		.rd_data (ctrl_rd),
		.wr_en   (ctrl_we),
		.wr_idx  (qidx_s1),
		.wr_data (ctrl_nx)
	);

	mde_item_store u_items (
		.clk     (clk),
		.wr_en   (item_we),
		.wr_addr (item_addr),
		.wr_data (data_s1),
		.rd_en   (item_re),
		.rd_addr (item_addr),
		.rd_data (item_rd)
	);

	always_comb begin
		is_push  = (act_s1 == mde_pkg::ACT_PUSH_FRONT) || (act_s1 == mde_pkg::ACT_PUSH_BACK);
		is_pop   = (act_s1 == mde_pkg::ACT_POP_FRONT) || (act_s1 == mde_pkg::ACT_POP_BACK);
		is_peek  = (act_s1 == mde_pkg::ACT_PEEK_FRONT) || (act_s1 == mde_pkg::ACT_PEEK_BACK);
		at_front = !act_s1[0];

		ctrl_nx    = ctrl_rd;
		ctrl_we    = 1'b0;
		item_we    = 1'b0;
		item_re    = 1'b0;
		slot       = '0;
		res_status = mde_pkg::ST_OK;
		res_count  = ctrl_rd.count;

		if (!in_range_s1) begin
			res_count = '0;
			if (is_push) begin
				res_status = mde_pkg::ST_FULL;
			end else if (is_pop || is_peek) begin
				res_status = mde_pkg::ST_EMPTY;
			end
		end else if (is_push) begin
			if (ctrl_rd.count == CNT_W'(mde_pkg::QUEUE_DEPTH)) begin
				res_status = mde_pkg::ST_FULL;
			end else begin
				if (ctrl_rd.count == '0) begin
					slot          = '0;
					ctrl_nx.front = '0;
					ctrl_nx.back  = '0;
				end else if (at_front) begin
					// step the front down, wrapping at slot 0
					slot = (ctrl_rd.front == '0) ?
						SLOT_W'(mde_pkg::QUEUE_DEPTH - 1) : ctrl_rd.front - SLOT_W'(1);
					ctrl_nx.front = slot;
				end else begin
					slot = (ctrl_rd.back == SLOT_W'(mde_pkg::QUEUE_DEPTH - 1)) ?
						'0 : ctrl_rd.back + SLOT_W'(1);
					ctrl_nx.back = slot;
				end
				ctrl_nx.count = ctrl_rd.count + CNT_W'(1);
				res_count     = ctrl_nx.count;
				ctrl_we       = 1'b1;
				item_we       = 1'b1;
			end
		end else if (is_pop || is_peek) begin
			if (ctrl_rd.count == '0) begin
				res_status = mde_pkg::ST_EMPTY;
			end else begin
				slot    = at_front ? ctrl_rd.front : ctrl_rd.back;
				item_re = 1'b1;
				if (is_pop) begin
					ctrl_nx.count = ctrl_rd.count - CNT_W'(1);
					res_count     = ctrl_nx.count;
					ctrl_we       = 1'b1;
					if (ctrl_nx.count == '0) begin
						// last item gone: restart both ends at slot 0
						ctrl_nx.front = '0;
						ctrl_nx.back  = '0;
					end else if (at_front) begin
						ctrl_nx.front = (slot == SLOT_W'(mde_pkg::QUEUE_DEPTH - 1)) ?
							'0 : slot + SLOT_W'(1);
					end else begin
						ctrl_nx.back = (slot == '0) ?
							SLOT_W'(mde_pkg::QUEUE_DEPTH - 1) : slot - SLOT_W'(1);
					end
				end
			end
		end

		// memory ops only fire in the modify cycle
		if (state_q != S_CTRL) begin
			ctrl_we = 1'b0;
			item_we = 1'b0;
			item_re = 1'b0;
		end

		item_addr = ADDR_W'(qidx_s1) * ADDR_W'(mde_pkg::QUEUE_DEPTH) + ADDR_W'(slot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CTRL;
					end
				end
				S_CTRL: begin
					if (item_re) begin
						state_q <= S_DATA;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DATA: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1      <= action;
			qidx_s1     <= QSEL_W'(queue_id);
			in_range_s1 <= (32'(queue_id) < mde_pkg::NUM_QUEUES);
			data_s1     <= IW'(item_data);
		end
		if (state_q == S_CTRL) begin
			status_s2 <= res_status;
			size_s2   <= 9'(res_count);
			if (!item_re) begin
				status_q     <= res_status;
				item_out_q   <= '0;
				queue_size_q <= 9'(res_count);
			end
		end
		if (state_q == S_DATA) begin
			status_q     <= status_s2;
			item_out_q   <= 64'(item_rd);
			queue_size_q <= size_s2;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign item_out   = item_out_q;
	assign queue_size = queue_size_q;

	a_accept_to_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_CTRL))
		else $error("accepted request did not enter the control cycle");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_CTRL || $past(state_q) == S_DATA))
		else $error("result strobe without a request in flight");

	a_fail_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != mde_pkg::ST_OK) |-> (item_out == '0))
		else $error("failed request returned an item");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(queue_size) <= mde_pkg::QUEUE_DEPTH))
		else $error("queue size beyond capacity");

endmodule

[hdl/mde_ctrl_store.sv]
// ----------------------------------------------------------------------------
// mde_ctrl_store
// Per-queue front, back and count words; one write and one registered read
// port. Valid bits make a never-written queue read as empty.
// ----------------------------------------------------------------------------
module mde_ctrl_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [mde_pkg::QSEL_W-1:0]  rd_idx,
	output mde_pkg::ctrl_t              rd_data,
	input  logic                        wr_en,
	input  logic [mde_pkg::QSEL_W-1:0]  wr_idx,
	input  mde_pkg::ctrl_t              wr_data
);

	mde_pkg::ctrl_t                     mem [mde_pkg::NUM_QUEUES];
	logic [mde_pkg::NUM_QUEUES-1:0]     valid_q;
	mde_pkg::ctrl_t                     rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_idx] ? mem[rd_idx] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/mde_item_store.sv]
// ----------------------------------------------------------------------------
// mde_item_store
// Item words of all queues, one ring of slots per queue; one write port and
// one read port with registered data.
// ----------------------------------------------------------------------------
module mde_item_store (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [mde_pkg::ADDR_W-1:0]      wr_addr,
	input  logic [mde_pkg::ITEM_WIDTH-1:0]  wr_data,
	input  logic                            rd_en,
	input  logic [mde_pkg::ADDR_W-1:0]      rd_addr,
	output logic [mde_pkg::ITEM_WIDTH-1:0]  rd_data
);

	logic [mde_pkg::ITEM_WIDTH-1:0] mem [mde_pkg::STORE_DEPTH];
	logic [mde_pkg::ITEM_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-deque engine. A shadow of every queue's
// ends, fill level and slots predicts each reply; replies are matched in
// order, field by field. Directed requests hit empty queues, wrapping ends
// and the afresh restart, then random fill, drain and mixed traffic drives
// queues to full and back to empty under varying request gaps.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
	localparam logic [2:0] ACT_UNUSED_7 = 3'd7;
	localparam int RANDOM_REQUESTS = 1152;
	localparam int SEGMENT_LEN     = 192;
	localparam int CYCLE_LIMIT     = 100000;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] item;
		logic [8:0]  size;
	} reply_t;

	class deque_scoreboard;
		logic [mde_pkg::SLOT_W-1:0]     head_slot [mde_pkg::NUM_QUEUES];
		logic [mde_pkg::SLOT_W-1:0]     tail_slot [mde_pkg::NUM_QUEUES];
		int unsigned                    fill_level [mde_pkg::NUM_QUEUES];
		logic [mde_pkg::ITEM_WIDTH-1:0] slots [mde_pkg::STORE_DEPTH];
		reply_t                         pending_replies [$];
		int                             mismatches;
		int                             replies_checked;
		int                             full_answers;
		int                             empty_answers;

		function new();
			for (int q = 0; q < mde_pkg::NUM_QUEUES; q++) begin
				head_slot[q]  = '0;
				tail_slot[q]  = '0;
				fill_level[q] = 0;
			end
			mismatches      = 0;
			replies_checked = 0;
			full_answers    = 0;
			empty_answers   = 0;
		endfunction

		// Apply one accepted request to the shadow queues and queue its reply.
		function void note_request(logic [2:0] act, logic [3:0] qid, logic [63:0] data);
			reply_t                     r;
			int                         q;
			int unsigned                n;
			logic [mde_pkg::SLOT_W-1:0] s;
			bit                         at_front;
			r.status = mde_pkg::ST_OK;
			r.item   = '0;
			r.size   = '0;
			if (qid >= mde_pkg::NUM_QUEUES) begin
				if (act == mde_pkg::ACT_PUSH_FRONT || act == mde_pkg::ACT_PUSH_BACK)
					r.status = mde_pkg::ST_FULL;
				else if (act != ACT_UNUSED_6 && act != ACT_UNUSED_7)
					r.status = mde_pkg::ST_EMPTY;
			end else begin
				q = int'(qid);
				n = fill_level[q];
				at_front = (act == mde_pkg::ACT_PUSH_FRONT || act == mde_pkg::ACT_POP_FRONT ||
					act == mde_pkg::ACT_PEEK_FRONT);
				case (act)
					mde_pkg::ACT_PUSH_FRONT, mde_pkg::ACT_PUSH_BACK: begin
						if (n >= mde_pkg::QUEUE_DEPTH) begin
							r.status = mde_pkg::ST_FULL;
						end else begin
							if (n == 0) begin
								s = '0;
								head_slot[q] = '0;
								tail_slot[q] = '0;
							end else if (at_front) begin
								s = head_slot[q] - 1'b1;
								head_slot[q] = s;
							end else begin
								s = tail_slot[q] + 1'b1;
								tail_slot[q] = s;
							end
							slots[q * mde_pkg::QUEUE_DEPTH + s] = data[mde_pkg::ITEM_WIDTH-1:0];
							n++;
						end
					end
					mde_pkg::ACT_POP_FRONT, mde_pkg::ACT_POP_BACK,
					mde_pkg::ACT_PEEK_FRONT, mde_pkg::ACT_PEEK_BACK: begin
						if (n == 0) begin
							r.status = mde_pkg::ST_EMPTY;
						end else begin
							s = at_front ? head_slot[q] : tail_slot[q];
							r.item[mde_pkg::ITEM_WIDTH-1:0] = slots[q * mde_pkg::QUEUE_DEPTH + s];
							if (act == mde_pkg::ACT_POP_FRONT || act == mde_pkg::ACT_POP_BACK) begin
								n--;
								// an emptied queue starts over at slot 0
								if (n == 0) begin
									head_slot[q] = '0;
									tail_slot[q] = '0;
								end else if (at_front) begin
									head_slot[q] = s + 1'b1;
								end else begin
									tail_slot[q] = s - 1'b1;
								end
							end
						end
					end
					default: ;
				endcase
				fill_level[q] = n;
				r.size = 9'(n);
			end
			pending_replies = {pending_replies, r};
		endfunction

		function void check_reply(logic [1:0] st, logic [63:0] item, logic [8:0] size);
			reply_t e;
			if (pending_replies.size() == 0) begin
				$display("%0t: result with none expected: status %0d item %h size %0d",
					$time, st, item, size);
				mismatches++;
				return;
			end
			e = pending_replies.pop_front();
			replies_checked++;
			if (e.status == mde_pkg::ST_FULL)
				full_answers++;
			if (e.status == mde_pkg::ST_EMPTY)
				empty_answers++;
			if (st !== e.status) begin
				$display("%0t: status expected %0d, got %0d", $time, e.status, st);
				mismatches++;
			end
			if (item !== e.item) begin
				$display("%0t: item_out expected %h, got %h", $time, e.item, item);
				mismatches++;
			end
			if (size !== e.size) begin
				$display("%0t: queue_size expected %0d, got %0d", $time, e.size, size);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  action;
	logic [3:0]  queue_id;
	logic [63:0] item_data;
	logic        done;
	logic [1:0]  status;
	logic [63:0] item_out;
	logic [8:0]  queue_size;

	deque_scoreboard sb = new();
	int idle_pct;
	int requests_sent;
	int cycles = 0;

	multi_deque_engine_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.queue_id  (queue_id),
		.item_data (item_data),
		.done      (done),
		.status    (status),
		.item_out  (item_out),
		.queue_size(queue_size)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_reply(status, item_out, queue_size);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Hold the request until a transfer, then maybe idle for a random gap.
	task automatic send_request(input logic [2:0] act, input logic [3:0] qid,
		input logic [63:0] data);
		int gap;
		start     = 1'b1;
		action    = act;
		queue_id  = qid;
		item_data = data;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(act, qid, data);
		requests_sent++;
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			start = 1'b0;
			repeat (gap) begin
				action    = 3'($urandom_range(7));
				queue_id  = 4'($urandom_range(15));
				item_data = {$urandom(), $urandom()};
				@(negedge clk);
			end
		end
	endtask

	task automatic send_random(input traffic_mode_t mode, input logic [3:0] focus);
		int          r;
		logic [2:0]  act;
		logic [3:0]  qid;
		r = $urandom_range(99);
		case (mode)
			MODE_FILL: begin
				if (r < 94)      act = 3'(mde_pkg::ACT_PUSH_FRONT + $urandom_range(1));
				else if (r < 97) act = 3'(mde_pkg::ACT_PEEK_FRONT + $urandom_range(1));
				else if (r < 99) act = 3'(mde_pkg::ACT_POP_FRONT + $urandom_range(1));
				else             act = 3'(ACT_UNUSED_6 + $urandom_range(1));
			end
			MODE_DRAIN: begin
				if (r < 90)      act = 3'(mde_pkg::ACT_POP_FRONT + $urandom_range(1));
				else if (r < 95) act = 3'(mde_pkg::ACT_PEEK_FRONT + $urandom_range(1));
				else if (r < 99) act = 3'(mde_pkg::ACT_PUSH_FRONT + $urandom_range(1));
				else             act = 3'(ACT_UNUSED_6 + $urandom_range(1));
			end
			default: begin
				if (r < 96) act = 3'($urandom_range(mde_pkg::ACT_PEEK_BACK));
				else        act = 3'(ACT_UNUSED_6 + $urandom_range(1));
			end
		endcase
		if (mode == MODE_MIXED)
			qid = $urandom_range(1) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
		else
			qid = ($urandom_range(99) < 95) ? focus : 4'($urandom_range(15));
		send_request(act, qid, {$urandom(), $urandom()});
	endtask

	initial begin
		int            phase_idle [4];
		traffic_mode_t seg_mode [6];
		logic [3:0]    focus;
		phase_idle = '{0, 62, 0, 36};
		seg_mode   = '{MODE_FILL, MODE_FILL, MODE_DRAIN, MODE_DRAIN, MODE_MIXED, MODE_MIXED};
		arst_n    = 1'b0;
		start     = 1'b0;
		action    = '0;
		queue_id  = '0;
		item_data = '0;
		idle_pct  = 0;
		requests_sent = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty queues and unused codes
		send_request(mde_pkg::ACT_POP_FRONT,  4'd0,  64'h0123_4567_89AB_CDEF);
		send_request(mde_pkg::ACT_PEEK_BACK,  4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(mde_pkg::ACT_POP_BACK,   4'd0,  64'h0);
		send_request(mde_pkg::ACT_PEEK_FRONT, 4'd3,  64'h0);
		send_request(ACT_UNUSED_6,            4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
		// front push into a non-empty queue wraps below slot 0
		send_request(mde_pkg::ACT_PUSH_BACK,  4'd0,  64'h0);
		send_request(mde_pkg::ACT_PUSH_FRONT, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
		send_request(mde_pkg::ACT_PUSH_BACK,  4'd0,  64'h5555_5555_5555_5555);
		send_request(mde_pkg::ACT_PEEK_FRONT, 4'd0,  64'h0);
		send_request(mde_pkg::ACT_PEEK_BACK,  4'd0,  64'h0);
		send_request(ACT_UNUSED_7,            4'd0,  64'h0);
		send_request(mde_pkg::ACT_POP_FRONT,  4'd0,  64'h0);
		send_request(mde_pkg::ACT_POP_BACK,   4'd0,  64'h0);
		send_request(mde_pkg::ACT_POP_BACK,   4'd0,  64'h0);
		// emptied queue restarts afresh
		send_request(mde_pkg::ACT_PUSH_FRONT, 4'd0,  64'hAAAA_AAAA_AAAA_AAAA);
		send_request(mde_pkg::ACT_PEEK_BACK,  4'd0,  64'h0);
		send_request(mde_pkg::ACT_PUSH_FRONT, 4'd15, 64'h8000_0000_0000_0001);
		send_request(mde_pkg::ACT_PUSH_BACK,  4'd15, 64'h7FFF_FFFF_FFFF_FFFE);
		send_request(mde_pkg::ACT_POP_FRONT,  4'd15, 64'h0);
		send_request(mde_pkg::ACT_POP_FRONT,  4'd15, 64'h0);
		send_request(mde_pkg::ACT_PEEK_FRONT, 4'd15, 64'h0);
		send_request(mde_pkg::ACT_PUSH_BACK,  4'd7,  64'hDEAD_BEEF_0000_FFFF);
		send_request(mde_pkg::ACT_POP_FRONT,  4'd7,  64'h0);

		focus = 4'($urandom_range(15));
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			idle_pct = phase_idle[(i * 4) / RANDOM_REQUESTS];
			send_random(seg_mode[i / SEGMENT_LEN], focus);
		end
		start = 1'b0;

		while (sb.pending_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests over four gap phases; %0d replies checked.",
			requests_sent, sb.replies_checked);
		$display("Replies included %0d full and %0d empty refusals; %0d mismatches.",
			sb.full_answers, sb.empty_answers, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
hdl/mde_pkg.sv
hdl/mde_ctrl_store.sv
hdl/mde_item_store.sv
hdl/multi_deque_engine_top.sv
tb/sv/tb.sv
